>>> rtl/hcsl_pkg.sv
package hcsl_pkg;

	// queue between front and back
	localparam int QDepth = 2;
	localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW  = $clog2(QDepth + 1);

	// speed conversion constants
	localparam logic signed [15:0] TICK_LIMIT  = 16'sd240;
	localparam logic signed [23:0] SPEED_SCALE = 24'sd100;
	localparam logic signed [15:0] TICK_MAX    = 16'sh7fff;
	localparam logic signed [15:0] TICK_MIN    = 16'sh8000;

	// hall codes that carry no position
	localparam logic [2:0] HALL_NONE_LO = 3'd0;
	localparam logic [2:0] HALL_NONE_HI = 3'd7;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_GAIN       = 3'd0,
		REG_DUTY_MAX   = 3'd1,
		REG_DUTY_MIN   = 3'd2,
		REG_SPEED_HIGH = 3'd3,
		REG_SPEED_LOW  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        gain;
		logic [14:0]        duty_max;
		logic signed [15:0] duty_min;
		logic signed [15:0] speed_high;
		logic signed [15:0] speed_low;
	} cfg_regs_t;

	typedef struct packed {
		logic               command;
		logic               hall_a;
		logic               hall_b;
		logic               hall_c;
		logic signed [15:0] speed_target;
	} in_word_t;

	typedef struct packed {
		logic               gate_a_high;
		logic               gate_a_low;
		logic               gate_b_high;
		logic               gate_b_low;
		logic               gate_c_high;
		logic               gate_c_low;
		logic               forward;
		logic [15:0]        duty;
		logic signed [15:0] speed;
	} out_word_t;

	// classified word handed from front to back
	typedef struct packed {
		logic               tick;
		logic [2:0]         code;
		logic signed [15:0] speed;
		logic signed [15:0] target;
	} q_word_t;

	// status of the queue as seen by its two sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// clockwise predecessor of each hall code
	function automatic logic [2:0] cw_pred(input logic [2:0] code);
		logic [2:0] p;
		unique case (code)
			3'd1:    p = 3'd3;
			3'd2:    p = 3'd6;
			3'd3:    p = 3'd2;
			3'd4:    p = 3'd5;
			3'd5:    p = 3'd1;
			3'd6:    p = 3'd4;
			default: p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/hcsl_front.sv
module hcsl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  hcsl_pkg::in_word_t word,
	input  hcsl_pkg::cfg_regs_t cfg,
	input  hcsl_pkg::q_stat_t  qstat,
	output logic               in_stall,
	output logic               push,
	output hcsl_pkg::q_word_t  entry
);
	import hcsl_pkg::*;

	logic [2:0]         last_q, last_next;
	logic signed [15:0] tick_q, tick_next;
	logic signed [15:0] speed_q, speed_next;
	logic [2:0]         code;
	logic signed [23:0] scaled;
	logic signed [15:0] spd;
	logic               accept;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !qstat.full;
	assign push     = accept;

	// classify the word, count hall steps, convert ticks to speed
	always_comb begin
		code       = {word.hall_a, word.hall_b, word.hall_c};
		scaled     = 24'(tick_q) * SPEED_SCALE;
		last_next  = last_q;
		tick_next  = tick_q;
		speed_next = speed_q;
		priority if (tick_q > TICK_LIMIT) begin
			spd = cfg.speed_high;
		end else if (tick_q < -TICK_LIMIT) begin
			spd = cfg.speed_low;
		end else begin
			spd = signed'(scaled[15:0]);
		end
		entry.target = word.speed_target;
		if (word.command) begin
			tick_next    = '0;
			speed_next   = spd;
			entry.tick   = 1'b1;
			entry.code   = last_q;
			entry.speed  = spd;
		end else begin
			if (code != last_q && code != HALL_NONE_LO && code != HALL_NONE_HI) begin
				if (last_q == cw_pred(code)) begin
					if (tick_q != TICK_MAX) tick_next = tick_q + 16'sd1;
				end else begin
					if (tick_q != TICK_MIN) tick_next = tick_q - 16'sd1;
				end
			end
			last_next    = code;
			entry.tick   = 1'b0;
			entry.code   = code;
			entry.speed  = speed_q;
		end
	end

	// hold front state, advance on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			tick_q  <= '0;
			speed_q <= '0;
		end else if (accept) begin
			last_q  <= last_next;
			tick_q  <= tick_next;
			speed_q <= speed_next;
		end
	end

endmodule

>>> rtl/hcsl_fifo.sv
module hcsl_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hcsl_pkg::q_word_t wr_word,
	input  logic              pop,
	output hcsl_pkg::q_word_t rd_word,
	output hcsl_pkg::q_stat_t qstat
);
	import hcsl_pkg::*;

	q_word_t            mem_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0]   count_q;
	logic               do_push, do_pop;

	assign qstat.full  = (count_q == QCntW'(QDepth));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_word     = mem_q[rd_ptr_q];

	// store pushed words
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_word;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/hcsl_back.sv
module hcsl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hcsl_pkg::q_word_t   rd_word,
	input  hcsl_pkg::q_stat_t   qstat,
	input  hcsl_pkg::cfg_regs_t cfg,
	input  logic                out_stall,
	output logic                pop,
	output logic                out_valid,
	output hcsl_pkg::out_word_t out_data
);
	import hcsl_pkg::*;

	// stage 1: error times gain
	logic               v_s1;
	q_word_t            w_s1;
	logic signed [32:0] prod_s1;
	// stage 2: output word
	logic               v_s2;
	out_word_t          out_s2;

	logic               sense_q, sense_next;
	logic [15:0]        duty_q, duty_next;
	logic               en_s1, en_s2;
	logic signed [16:0] err;
	logic signed [33:0] prod;
	logic signed [32:0] shifted;
	logic signed [24:0] cmd, clamped, neg, dmin, dmax;
	logic [2:0]         c;
	logic               p_a, n_a, p_b, n_b, p_c, n_c;

	assign en_s2     = !v_s2 || !out_stall;
	assign en_s1     = !v_s1 || en_s2;
	assign pop       = en_s1 && !qstat.empty;
	assign out_valid = v_s2;
	assign out_data  = out_s2;

	// form error and product
	always_comb begin
		err  = 17'(rd_word.target) - 17'(rd_word.speed);
		prod = 34'(err) * signed'({18'd0, cfg.gain});
	end

	// scale, clamp and split into direction and magnitude
	always_comb begin
		shifted    = prod_s1 >>> 8;
		cmd        = signed'(shifted[24:0]);
		dmin       = 25'(cfg.duty_min);
		dmax       = signed'({10'd0, cfg.duty_max});
		sense_next = sense_q;
		duty_next  = duty_q;
		priority if (cmd < dmin) begin
			clamped = dmin;
		end else if (cmd > dmax) begin
			clamped = dmax;
		end else begin
			clamped = cmd;
		end
		neg = -clamped;
		if (w_s1.tick) begin
			priority if (clamped >= 25'sd0 && clamped <= dmax) begin
				sense_next = 1'b1;
				duty_next  = clamped[15:0];
			end else if (clamped >= dmin && clamped < 25'sd0) begin
				sense_next = 1'b0;
				duty_next  = neg[15:0];
			end else begin
				sense_next = 1'b1;
				duty_next  = '0;
			end
		end
	end

	// commutation from hall code and direction
	always_comb begin
		c   = w_s1.code;
		p_a = c[2] & ~c[1];
		n_a = ~c[2] & c[1];
		p_b = c[1] & ~c[0];
		n_b = ~c[1] & c[0];
		p_c = ~c[2] & c[0];
		n_c = c[2] & ~c[0];
	end

	// advance the back pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sense_q <= 1'b1;
			duty_q  <= '0;
		end else begin
			if (en_s1) v_s1 <= !qstat.empty;
			if (en_s2) begin
				v_s2 <= v_s1;
				if (v_s1) begin
					sense_q <= sense_next;
					duty_q  <= duty_next;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			w_s1    <= rd_word;
			prod_s1 <= prod[32:0];
		end
		if (en_s2 && v_s1) begin
			out_s2.gate_a_high <= sense_next ? p_a : n_a;
			out_s2.gate_a_low  <= sense_next ? n_a : p_a;
			out_s2.gate_b_high <= sense_next ? p_b : n_b;
			out_s2.gate_b_low  <= sense_next ? n_b : p_b;
			out_s2.gate_c_high <= sense_next ? p_c : n_c;
			out_s2.gate_c_low  <= sense_next ? n_c : p_c;
			out_s2.forward     <= sense_next;
			out_s2.duty        <= duty_next;
			out_s2.speed       <= w_s1.speed;
		end
	end

endmodule

>>> rtl/hall_commutation_speed_loop.sv
// A word accepted at the input is written into the queue, then registered into
// stage 1 and then into the stage 2 output word when the output is not stalled.
// Throughput: one word per cycle unless stalled; a two-word queue parts the front
// from the two-stage multiply and clamp pipeline, so each side stalls on its own.
// Reset: arst_n clears hall code, ticks, speed and duty, sets forward, and
// restores all configuration registers to their defaults.
module hall_commutation_speed_loop (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  hcsl_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output hcsl_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import hcsl_pkg::*;

	cfg_regs_t cfg_q;
	q_word_t   push_word, pop_word;
	q_stat_t   qstat;
	logic      push, pop;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain       <= 16'd256;
			cfg_q.duty_max   <= 15'd1000;
			cfg_q.duty_min   <= -16'sd1000;
			cfg_q.speed_high <= 16'sd24000;
			cfg_q.speed_low  <= -16'sd24000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAIN:       cfg_q.gain       <= cfg_data;
				REG_DUTY_MAX:   cfg_q.duty_max   <= cfg_data[14:0];
				REG_DUTY_MIN:   cfg_q.duty_min   <= signed'(cfg_data);
				REG_SPEED_HIGH: cfg_q.speed_high <= signed'(cfg_data);
				REG_SPEED_LOW:  cfg_q.speed_low  <= signed'(cfg_data);
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	hcsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.word     (in_data),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.in_stall (in_stall),
		.push     (push),
		.entry    (push_word)
	);

	hcsl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_word (push_word),
		.pop     (pop),
		.rd_word (pop_word),
		.qstat   (qstat)
	);

	hcsl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_word   (pop_word),
		.qstat     (qstat),
		.cfg       (cfg_q),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	// reverse drive always carries a nonzero duty
	a_reverse_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.forward |-> out_data.duty != 16'd0)
		else $error("reverse drive with zero duty");

	// never both switches of one phase on
	a_no_shoot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.gate_a_high && out_data.gate_a_low) &&
			!(out_data.gate_b_high && out_data.gate_b_low) &&
			!(out_data.gate_c_high && out_data.gate_c_low))
		else $error("phase shoot-through");

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result word changed");
`endif

endmodule
